FILE: src/cpg_pkg.sv
// Shared constants and command codes of the circle point generator.
`default_nettype none

package cpg_pkg;

  localparam int unsigned COORD_BITS_DEF  = 11;
  localparam int unsigned RADIUS_BITS_DEF = 10;
  localparam int unsigned COLOR_W         = 24;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned POINTS_PER_GRP  = 8;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

endpackage

`default_nettype wire

FILE: src/cartesian_circle_point_generator.sv
// Top level of the naive Cartesian circle point generator.
//
//  channel  direction  transfer when            payload
//  -------  ---------  -----------------------  ---------------------------------------------
//  in       sink       in_valid_i & in_ready_o  cmd, center_x, center_y, radius, color
//  out      source     out_valid_o & out_ready_i pixel_x, pixel_y, pixel_color, last, done
//
//  A start goes from idle straight to push in the front end; an advance steps through
//  multiply, subtract, the one-bit-per-cycle square-root loop and push. The back end emits
//  8 points per group, one per cycle unless the output stalls, then pulls the next group.
//  Reset is asynchronous, active low; it clears all state (no circle in progress).
//  The two-entry group queue lets the front end compute while the output is stalled.
`default_nettype none

module cartesian_circle_point_generator #(
  parameter int unsigned COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        cmd_i,
  input  wire logic [COORD_BITS-1:0]       center_x_i,
  input  wire logic [COORD_BITS-1:0]       center_y_i,
  input  wire logic [RADIUS_BITS-1:0]      radius_i,
  input  wire logic [cpg_pkg::COLOR_W-1:0] color_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [COORD_BITS+1:0]     pixel_x_o,
  output logic signed [COORD_BITS+1:0]     pixel_y_o,
  output logic [cpg_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic                             last_of_group_o,
  output logic                             circle_done_o
);
  import cpg_pkg::*;

  // Group record: center, offsets, color, final flag.
  localparam int unsigned GRP_W = 2 * COORD_BITS + 2 * RADIUS_BITS + COLOR_W + 1;

  logic             push_valid;
  logic             push_ready;
  logic [GRP_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [GRP_W-1:0] pop_data;

  // Classify commands, hold circle state, derive each group's offsets.
  cpg_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .GRP_W       (GRP_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .radius_i     (radius_i),
    .color_i      (color_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Buffer finished groups so either side can stall independently.
  cpg_queue #(
    .DATA_W (GRP_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Mirror each group into eight points and hold them in the output register.
  cpg_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .GRP_W       (GRP_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_color_o   (pixel_color_o),
    .last_of_group_o (last_of_group_o),
    .circle_done_o   (circle_done_o)
  );

endmodule

`default_nettype wire

FILE: src/cpg_front.sv
// Front end: accepts commands, tracks circle state, computes the next (x, y) offset pair.
`default_nettype none

module cpg_front #(
  parameter int unsigned COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF,
  parameter int unsigned GRP_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + cpg_pkg::COLOR_W + 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        cmd_i,
  input  wire logic [COORD_BITS-1:0]       center_x_i,
  input  wire logic [COORD_BITS-1:0]       center_y_i,
  input  wire logic [RADIUS_BITS-1:0]      radius_i,
  input  wire logic [cpg_pkg::COLOR_W-1:0] color_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output logic [GRP_W-1:0]                 push_data_o
);
  import cpg_pkg::*;

  localparam int unsigned SQ_W  = 2 * RADIUS_BITS;
  localparam int unsigned CNT_W = $clog2(RADIUS_BITS);

  typedef struct packed {
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
    logic [COLOR_W-1:0]     color;
    logic                   done;
  } grp_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SUB,
    F_ROOT,
    F_PUSH
  } front_state_e;

  front_state_e           state_q;
  logic [COORD_BITS-1:0]  cx_q;
  logic [COORD_BITS-1:0]  cy_q;
  logic [RADIUS_BITS-1:0] rad_q;
  logic [COLOR_W-1:0]     color_q;
  logic [RADIUS_BITS-1:0] x_q;
  logic [RADIUS_BITS-1:0] y_q;
  logic                   active_q;
  logic [SQ_W-1:0]        r2_q;
  logic [SQ_W-1:0]        x2_q;
  logic [SQ_W-1:0]        rem_q;
  logic [SQ_W-1:0]        root_q;
  logic [CNT_W-1:0]       cnt_q;

  logic [SQ_W-1:0] bit_w;
  logic [SQ_W-1:0] trial_w;
  logic            done_w;
  grp_t            grp_w;

  // One bit of the root per cycle: bit weight is 4^cnt.
  assign bit_w   = SQ_W'(1) << {cnt_q, 1'b0};
  assign trial_w = root_q + bit_w;
  assign done_w  = !(x_q < y_q);

  always_comb begin
    grp_w.cx    = cx_q;
    grp_w.cy    = cy_q;
    grp_w.x     = x_q;
    grp_w.y     = y_q;
    grp_w.color = color_q;
    grp_w.done  = done_w;
  end

  assign in_ready_o   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = grp_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      cx_q     <= '0;
      cy_q     <= '0;
      rad_q    <= '0;
      color_q  <= '0;
      x_q      <= '0;
      y_q      <= '0;
      active_q <= 1'b0;
      r2_q     <= '0;
      x2_q     <= '0;
      rem_q    <= '0;
      root_q   <= '0;
      cnt_q    <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            if (cmd_i == CMD_START) begin
              cx_q    <= center_x_i;
              cy_q    <= center_y_i;
              rad_q   <= radius_i;
              color_q <= color_i;
              x_q     <= '0;
              y_q     <= radius_i;
              state_q <= F_PUSH;
            end else if (active_q) begin
              x_q     <= x_q + RADIUS_BITS'(1);
              state_q <= F_MUL;
            end
          end
        end
        F_MUL: begin
          r2_q    <= SQ_W'(rad_q) * SQ_W'(rad_q);
          x2_q    <= SQ_W'(x_q) * SQ_W'(x_q);
          state_q <= F_SUB;
        end
        F_SUB: begin
          if (x2_q <= r2_q) begin
            rem_q   <= r2_q - x2_q;
            root_q  <= '0;
            cnt_q   <= CNT_W'(RADIUS_BITS - 1);
            state_q <= F_ROOT;
          end else begin
            y_q     <= '0;
            state_q <= F_PUSH;
          end
        end
        F_ROOT: begin
          if (rem_q >= trial_w) begin
            rem_q  <= rem_q - trial_w;
            root_q <= (root_q >> 1) + bit_w;
          end else begin
            root_q <= root_q >> 1;
          end
          if (cnt_q == '0) begin
            state_q <= F_PUSH;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        F_PUSH: begin
          // root_q is only meaningful after a root pass; the start path loads y_q directly
          if (push_ready_i) begin
            active_q <= !done_w;
            state_q  <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
      // Capture the finished root on the last iteration.
      if (state_q == F_ROOT && cnt_q == '0) begin
        if (rem_q >= trial_w) begin
          y_q <= RADIUS_BITS'((root_q >> 1) + bit_w);
        end else begin
          y_q <= RADIUS_BITS'(root_q >> 1);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/cpg_queue.sv
// Short FIFO that decouples the offset front end from the point emitter.
`default_nettype none

module cpg_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output logic [DATA_W-1:0]      pop_data_o
);
  import cpg_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push_w;
  logic              pop_w;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push_w       = push_valid_i && push_ready_o;
  assign pop_w        = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_w) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_w) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_w) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_w && !pop_w) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_w && !push_w) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/cpg_back.sv
// Back end: expands one offset group into eight mirrored points behind an output register.
`default_nettype none

module cpg_back #(
  parameter int unsigned COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF,
  parameter int unsigned GRP_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + cpg_pkg::COLOR_W + 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        pop_valid_i,
  output logic                             pop_ready_o,
  input  wire logic [GRP_W-1:0]            pop_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [COORD_BITS+1:0]     pixel_x_o,
  output logic signed [COORD_BITS+1:0]     pixel_y_o,
  output logic [cpg_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic                             last_of_group_o,
  output logic                             circle_done_o
);
  import cpg_pkg::*;

  localparam int unsigned PIX_W = COORD_BITS + 2;
  localparam int unsigned SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam int unsigned K_W   = $clog2(POINTS_PER_GRP);

  typedef struct packed {
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
    logic [COLOR_W-1:0]     color;
    logic                   done;
  } grp_t;

  grp_t                    grp_q;
  logic                    busy_q;
  logic [K_W-1:0]          k_q;
  logic                    out_valid_q;
  logic signed [PIX_W-1:0] px_q;
  logic signed [PIX_W-1:0] py_q;
  logic [COLOR_W-1:0]      color_q;
  logic                    last_q;
  logic                    done_q;

  logic                    load_w;
  logic                    last_w;
  logic [RADIUS_BITS-1:0]  off_x_w;
  logic [RADIUS_BITS-1:0]  off_y_w;
  logic [SUM_W-1:0]        sum_x_w;
  logic [SUM_W-1:0]        sum_y_w;

  assign load_w      = busy_q && (!out_valid_q || out_ready_i);
  assign last_w      = (k_q == K_W'(POINTS_PER_GRP - 1));
  assign pop_ready_o = !busy_q;

  // Point index: bit 2 swaps the offsets, bit 0 negates the column, bit 1 the row.
  always_comb begin
    off_x_w = k_q[2] ? grp_q.y : grp_q.x;
    off_y_w = k_q[2] ? grp_q.x : grp_q.y;
    sum_x_w = k_q[0] ? SUM_W'(grp_q.cx) - SUM_W'(off_x_w) : SUM_W'(grp_q.cx) + SUM_W'(off_x_w);
    sum_y_w = k_q[1] ? SUM_W'(grp_q.cy) - SUM_W'(off_y_w) : SUM_W'(grp_q.cy) + SUM_W'(off_y_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q       <= '0;
      busy_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      color_q     <= '0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (!busy_q && pop_valid_i) begin
        grp_q  <= grp_t'(pop_data_i);
        busy_q <= 1'b1;
        k_q    <= '0;
      end
      if (load_w) begin
        px_q        <= PIX_W'(sum_x_w);
        py_q        <= PIX_W'(sum_y_w);
        color_q     <= grp_q.color;
        last_q      <= last_w;
        done_q      <= last_w && grp_q.done;
        out_valid_q <= 1'b1;
        k_q         <= k_q + K_W'(1);
        if (last_w) begin
          busy_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign pixel_color_o   = color_q;
  assign last_of_group_o = last_q;
  assign circle_done_o   = done_q;

endmodule

`default_nettype wire

FILE: src/cpg_checker.sv
// Port-level checks for the circle point generator, bound to the top level.
`default_nettype none

module cpg_checker #(
  parameter int unsigned COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        cmd_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [COORD_BITS+1:0]       pixel_x_o,
  input wire logic [COORD_BITS+1:0]       pixel_y_o,
  input wire logic [cpg_pkg::COLOR_W-1:0] pixel_color_o,
  input wire logic                        last_of_group_o,
  input wire logic                        circle_done_o
);
  import cpg_pkg::*;

  // A finished circle is only ever flagged on a group's eighth point.
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && circle_done_o |-> last_of_group_o)
    else $error("circle_done without last_of_group");

  // A start always yields a group, so the front end is busy the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_START) |=> !in_ready_o)
    else $error("input ready right after a start transfer");

  // A stalled point holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o)
      && $stable(pixel_color_o) && $stable(last_of_group_o) && $stable(circle_done_o))
    else $error("output changed while stalled");

  // Points of one group come on consecutive transfers: a group end is not repeated back to back.
  a_no_double_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_of_group_o |=> !(out_valid_o && last_of_group_o))
    else $error("two group ends in a row");

endmodule

bind cartesian_circle_point_generator cpg_checker #(
  .COORD_BITS  (COORD_BITS),
  .RADIUS_BITS (RADIUS_BITS)
) u_cpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .cmd_i           (cmd_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .pixel_x_o       (pixel_x_o),
  .pixel_y_o       (pixel_y_o),
  .pixel_color_o   (pixel_color_o),
  .last_of_group_o (last_of_group_o),
  .circle_done_o   (circle_done_o)
);

`default_nettype wire

FILE: tb/cartesian_circle_point_generator_tb.sv
// Self-checking testbench for the Cartesian circle point generator.
`timescale 1ns / 1ps

module cartesian_circle_point_generator_tb;

  localparam int CW       = cpg_pkg::COORD_BITS_DEF;
  localparam int RW       = cpg_pkg::RADIUS_BITS_DEF;
  localparam int PW       = CW + 2;
  localparam int COL_W    = cpg_pkg::COLOR_W;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic             cmd;
    logic [CW-1:0]    cx;
    logic [CW-1:0]    cy;
    logic [RW-1:0]    radius;
    logic [COL_W-1:0] color;
  } draw_cmd_t;

  typedef struct packed {
    logic [PW-1:0]    x;
    logic [PW-1:0]    y;
    logic [COL_W-1:0] color;
    logic             last;
    logic             done;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             in_valid_i = 1'b0;
  logic             cmd_i      = cpg_pkg::CMD_START;
  logic [CW-1:0]    center_x_i = '0;
  logic [CW-1:0]    center_y_i = '0;
  logic [RW-1:0]    radius_i   = '0;
  logic [COL_W-1:0] color_i    = '0;
  logic             out_ready_i = 1'b0;

  wire                  in_ready_o;
  wire                  out_valid_o;
  wire signed [PW-1:0]  pixel_x_o;
  wire signed [PW-1:0]  pixel_y_o;
  wire [COL_W-1:0]      pixel_color_o;
  wire                  last_of_group_o;
  wire                  circle_done_o;

  cartesian_circle_point_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_i       (radius_i),
    .color_i        (color_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .last_of_group_o(last_of_group_o),
    .circle_done_o  (circle_done_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  draw_cmd_t draw_cmds[$];         // commands waiting to be offered to the block
  pixel_t    predicted_pixels[$];  // points the block still owes us, oldest first

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int stall_cycles  = 0;

  // Shadow of the rasterizer state, advanced on every accepted command.
  logic [CW-1:0]    held_cx;
  logic [CW-1:0]    held_cy;
  logic [RW-1:0]    held_radius;
  logic [COL_W-1:0] held_color;
  logic [RW-1:0]    step_x;
  logic [RW-1:0]    step_y;
  logic             circle_active;

  // Floor square root, one result bit at a time from the top.
  function automatic logic [RW-1:0] int_sqrt(input logic [2*RW-1:0] v);
    logic [RW-1:0]   root;
    logic [RW-1:0]   trial;
    logic [2*RW-1:0] sq;
    root = '0;
    for (int b = RW - 1; b >= 0; b--) begin
      trial = root | (RW'(1) << b);
      sq = trial * trial;
      if (sq <= v) root = trial;
    end
    return root;
  endfunction

  // Height of the arc at column x; zero once x has passed the radius.
  function automatic logic [RW-1:0] arc_height(input logic [RW-1:0] r, input logic [RW-1:0] x);
    logic [2*RW-1:0] r2;
    logic [2*RW-1:0] x2;
    r2 = r * r;
    x2 = x * x;
    return (x2 <= r2) ? int_sqrt(r2 - x2) : '0;
  endfunction

  // Number of advances a circle of radius r takes to reach its final group.
  function automatic int steps_to_finish(input logic [RW-1:0] r);
    logic [RW-1:0] x;
    logic [RW-1:0] y;
    int n;
    x = '0;
    y = r;
    n = 0;
    while (x < y) begin
      x = x + 1'b1;
      y = arc_height(r, x);
      n++;
    end
    return n;
  endfunction

  // Apply one accepted command to the shadow state and queue the eight
  // mirrored points it produces. An advance with no circle running is dropped.
  task automatic rasterize_group(input draw_cmd_t c);
    logic [PW-1:0] a;
    logic [PW-1:0] b;
    logic          fin;
    pixel_t        p;
    if (c.cmd == cpg_pkg::CMD_START) begin
      held_cx     = c.cx;
      held_cy     = c.cy;
      held_radius = c.radius;
      held_color  = c.color;
      step_x      = '0;
      step_y      = c.radius;
    end else begin
      if (!circle_active) return;
      step_x = step_x + 1'b1;
      step_y = arc_height(held_radius, step_x);
    end
    fin = !(step_x < step_y);
    circle_active = !fin;
    // Points 0-3 mirror (x, y), points 4-7 mirror the swapped (y, x).
    for (int k = 0; k < cpg_pkg::POINTS_PER_GRP; k++) begin
      a = k[2] ? PW'(step_y) : PW'(step_x);
      b = k[2] ? PW'(step_x) : PW'(step_y);
      p.x     = k[0] ? PW'(held_cx) - a : PW'(held_cx) + a;
      p.y     = k[1] ? PW'(held_cy) - b : PW'(held_cy) + b;
      p.color = held_color;
      p.last  = (k == cpg_pkg::POINTS_PER_GRP - 1);
      p.done  = p.last && fin;
      predicted_pixels.push_back(p);
    end
  endtask

  // Compare one transferred point against the oldest prediction.
  task automatic check_pixel();
    pixel_t exp_p;
    pixel_t got;
    got = '{x: pixel_x_o, y: pixel_y_o, color: pixel_color_o,
            last: last_of_group_o, done: circle_done_o};
    if (predicted_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected point x=%0d y=%0d color=%h last=%b done=%b", $realtime,
                 $signed(got.x), $signed(got.y), got.color, got.last, got.done);
      return;
    end
    exp_p = predicted_pixels.pop_front();
    if (got !== exp_p) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: point mismatch exp x=%0d y=%0d color=%h last=%b done=%b,", $realtime,
                 $signed(exp_p.x), $signed(exp_p.y), exp_p.color, exp_p.last, exp_p.done,
                 " got x=%0d y=%0d color=%h last=%b done=%b",
                 $signed(got.x), $signed(got.y), got.color, got.last, got.done);
    end
  endtask

  // Driver: hold the payload until the transfer, then load the next command
  // or, when none is waiting or a random idle is drawn, drop valid.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      circle_active = 1'b0;
      held_cx = '0;
      held_cy = '0;
      held_radius = '0;
      held_color = '0;
      step_x = '0;
      step_y = '0;
    end else begin
      if (in_valid_i && in_ready_o)
        rasterize_group('{cmd: cmd_i, cx: center_x_i, cy: center_y_i,
                          radius: radius_i, color: color_i});
      if (!in_valid_i || in_ready_o) begin
        if (draw_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          cmd_i      <= draw_cmds[0].cmd;
          center_x_i <= draw_cmds[0].cx;
          center_y_i <= draw_cmds[0].cy;
          radius_i   <= draw_cmds[0].radius;
          color_i    <= draw_cmds[0].color;
          void'(draw_cmds.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every point transfer, then pick the next ready at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_pixel();
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: give up when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Advance with junk in the fields the block ignores on an advance.
  function automatic void queue_advance();
    draw_cmd_t c;
    c.cmd    = cpg_pkg::CMD_ADVANCE;
    c.cx     = CW'($urandom);
    c.cy     = CW'($urandom);
    c.radius = RW'($urandom);
    c.color  = COL_W'($urandom);
    draw_cmds.push_back(c);
  endfunction

  // Start a circle and follow it with some advances; return how many of
  // these commands, the start included, the block will actually draw from.
  function automatic int queue_circle(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                                      input logic [RW-1:0] r, input logic [COL_W-1:0] color,
                                      input int advances);
    int steps;
    draw_cmds.push_back('{cmd: cpg_pkg::CMD_START, cx: cx, cy: cy, radius: r, color: color});
    for (int i = 0; i < advances; i++) queue_advance();
    steps = steps_to_finish(r);
    return 1 + ((advances < steps) ? advances : steps);
  endfunction

  // Mostly small circles drawn to the end (sometimes with stray advances
  // after the final group), some cut short by the next start, and some
  // large radii that only get a few steps before being abandoned.
  task automatic queue_random_circles(input int target);
    int n;
    int sel;
    int steps;
    int advances;
    logic [RW-1:0] r;
    n = 0;
    while (n < target) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        r = RW'($urandom_range(24));
        steps = steps_to_finish(r);
        advances = (sel < 55) ? steps + $urandom_range(2) : $urandom_range(steps);
      end else begin
        r = RW'($urandom_range(1023));
        advances = $urandom_range(5);
      end
      n += queue_circle(CW'($urandom), CW'($urandom), r, COL_W'($urandom), advances);
    end
  endtask

  task automatic wait_drained();
    while (draw_cmds.size() != 0 || in_valid_i || predicted_pixels.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    send_idle_pct = 14;
    recv_idle_pct = 87;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: advance with no circle, zero radius, extreme centers and
    // radius, negative wrap, restart while a circle is running.
    queue_advance();
    void'(queue_circle('0, '0, '0, '0, 1));
    void'(queue_circle('1, '1, '1, '1, 3));
    void'(queue_circle('0, '0, '1, 24'h5A5A5A, 2));
    void'(queue_circle('0, '1, 1, 24'hA5A5A5, 2));
    void'(queue_circle(CW'(1024), CW'(1024), 2, 24'h123456, 2));
    void'(queue_circle(5, 3, 5, 24'h00FF00, steps_to_finish(5) + 1));
    void'(queue_circle('1, '0, 3, 24'h800001, steps_to_finish(3)));

    queue_random_circles(22);
    wait_drained();

    // Sender slow, receiver eager.
    send_idle_pct = 87;
    recv_idle_pct = 14;
    queue_random_circles(22);
    wait_drained();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_circles(22);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && predicted_pixels.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: cartesian_circle_point_generator.f
src/cpg_pkg.sv
src/cpg_front.sv
src/cpg_queue.sv
src/cpg_back.sv
src/cartesian_circle_point_generator.sv
src/cpg_checker.sv
tb/cartesian_circle_point_generator_tb.sv
